// File: sv/sidec_pkg.sv
// Shared constants and control types for the signed integer to decimal
// ASCII unit. No dependencies; imported by every other file of the block.
package sidec_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CntWidth   = $clog2(ValueWidth);
  localparam int unsigned IdxWidth   = $clog2(NumDigits);
  localparam int unsigned CharWidth  = 8;

  localparam logic [CharWidth-1:0] AsciiZero  = 8'd48;
  localparam logic [CharWidth-1:0] AsciiMinus = 8'd45;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a new value
    logic step;      // one shift-and-add-3 iteration
    logic lead;      // find the most significant non-zero digit
    logic dec_idx;   // move on to the next lower digit
    logic sel_sign;  // present the minus sign instead of a digit
  } sidec_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic conv_done; // final iteration is under way
    logic neg;       // captured value was negative
    logic idx_zero;  // current digit is the units digit
  } sidec_status_t;

endpackage

// File: sv/sidec_in_if.sv
// Input channel of the decimal ASCII unit: one signed 32-bit value per beat.
// Depends on sidec_pkg.
interface sidec_in_if import sidec_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: sv/sidec_out_if.sv
// Output channel of the decimal ASCII unit: one character per beat.
// Depends on sidec_pkg.
interface sidec_out_if import sidec_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] character;
  logic                 last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// File: sv/sidec_dp.sv
// Datapath of the decimal ASCII unit: magnitude and BCD shift registers,
// digit pointer and character selection. Depends on sidec_pkg.
module sidec_dp import sidec_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [ValueWidth-1:0] value_i,
  input  sidec_cmd_t                   cmd_i,
  output sidec_status_t                status_o,
  output logic [CharWidth-1:0]         character_o
);

  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d, bcd_adj;
  logic                  neg_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [IdxWidth-1:0]   idx_q, top_idx;
  logic [ValueWidth-1:0] raw;
  logic [3:0]            cur_digit;

  assign raw = value_i;

  // add-3 correction on every digit that would overflow when doubled
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign bcd_d = {bcd_adj[BcdWidth-2:0], mag_q[ValueWidth-1]};
  assign mag_d = {mag_q[ValueWidth-2:0], 1'b0};

  // most significant non-zero digit; units digit when all are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        top_idx = IdxWidth'(i);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= raw[ValueWidth-1];
      mag_q <= raw[ValueWidth-1] ? (~raw + 1'b1) : raw;
      bcd_q <= '0;
    end else if (cmd_i.step) begin
      mag_q <= mag_d;
      bcd_q <= bcd_d;
    end
  end

  // iteration counter and digit pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.lead) begin
        idx_q <= top_idx;
      end else if (cmd_i.dec_idx) begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

  assign character_o = cmd_i.sel_sign ? AsciiMinus : (AsciiZero + {4'b0000, cur_digit});

  assign status_o.conv_done = (cnt_q == {CntWidth{1'b1}});
  assign status_o.neg       = neg_q;
  assign status_o.idx_zero  = (idx_q == '0);

`ifndef NO_ASSERTIONS
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (cnt_q == '0) && (bcd_q == '0))
    else $error("load did not clear the converter");

  a_lead_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lead |=> (idx_q < IdxWidth'(NumDigits)))
    else $error("digit pointer beyond the top digit");

  a_digit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.lead) |-> (cur_digit <= 4'd9))
    else $error("converted digit is not decimal");
`endif

endmodule

// File: sv/sidec_ctrl.sv
// Controller of the decimal ASCII unit: sequences capture, conversion and
// character output. Depends on sidec_pkg.
module sidec_ctrl import sidec_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          out_last_o,
  input  sidec_status_t status_i,
  output sidec_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_LEAD  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.conv_done) begin
          state_d = S_LEAD;
        end
      end
      S_LEAD: begin
        cmd_o.lead = 1'b1;
        state_d    = status_i.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_sign = 1'b1;
        if (out_ready_i) begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        out_valid_o = 1'b1;
        out_last_o  = status_i.idx_zero;
        if (out_ready_i) begin
          if (status_i.idx_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.dec_idx = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_CONV))
    else $error("capture not followed by conversion");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_last_o |=> in_ready_o)
    else $error("not ready for a new value after the final character");

  a_no_out_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !out_valid_o && !in_ready_o)
    else $error("handshake open during conversion");
`endif

endmodule

// File: sv/signed_int_to_decimal_ascii_unit.sv
// Top level of the signed integer to decimal ASCII unit.
// Depends on sidec_pkg, sidec_in_if, sidec_out_if, sidec_ctrl and sidec_dp.

// Each accepted 32-bit two's complement value comes out as its decimal text,
// one ASCII character per output beat, most significant first: a leading '-'
// for negative values, no leading zeros, a single '0' for zero, and
// last_char set on the final digit; an item has 1 to 11 characters. Each item
// passes through capture, 32 iterations of the bit-serial shift-and-add-3
// binary to BCD converter and location of the leading digit, then comes out
// at one character per cycle while the output is not stalled. The input is
// ready only between items.
module signed_int_to_decimal_ascii_unit import sidec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sidec_in_if.sink    in_i,
  sidec_out_if.source out_o
);

  sidec_cmd_t           cmd;
  sidec_status_t        status;
  logic [CharWidth-1:0] character;
  logic                 out_valid;
  logic                 out_last;
  logic                 in_ready;

  sidec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_last_o  (out_last),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sidec_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (character)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.character = character;
  assign out_o.last_char = out_last;

endmodule
